@@ sv/epoch_seconds_to_calendar_assert.svh @@
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// Same-cycle implication, checked on clk, held off during reset.
`define ESC_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on clk, held off during reset.
`define ESC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ sv/esc_pkg.sv @@
package esc_pkg;

	localparam int unsigned WORD_W = 32;

	localparam logic [16:0] DAY_SECONDS  = 17'd86400;
	localparam logic [11:0] HOUR_SECONDS = 12'd3600;
	localparam logic [5:0]  MIN_SECONDS  = 6'd60;
	localparam logic [10:0] FIRST_YEAR   = 11'd1970;
	localparam logic [16:0] OFFSET_RESET = 17'd28800;

	// 1970 taken modulo 4, 100 and 400
	localparam logic [1:0] FIRST_Y4   = 2'd2;
	localparam logic [6:0] FIRST_Y100 = 7'd70;
	localparam logic [8:0] FIRST_Y400 = 9'd370;

	typedef struct packed {
		logic [10:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} esc_result_t;

	function automatic logic esc_is_leap(input logic [1:0] y4, input logic [6:0] y100,
		input logic [8:0] y400);
		return ((y4 == 2'd0) && (y100 != 7'd0)) || (y400 == 9'd0);
	endfunction

	function automatic logic [8:0] esc_year_len(input logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [8:0] esc_month_len(input logic [3:0] m, input logic leap);
		logic [8:0] len;
		if (m == 4'd2) begin
			len = leap ? 9'd29 : 9'd28;
		end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
			len = 9'd30;
		end else begin
			len = 9'd31;
		end
		return len;
	endfunction

endpackage

@@ sv/epoch_seconds_to_calendar.sv @@
// Epoch seconds to local calendar date and time.
// Input channel: in_valid / in_stall carry one request, epoch_seconds. A request
// is taken on a rising edge with in_valid high and in_stall low; in_stall stays
// high from then until the sequencer has finished the request.
// Output channel: out_valid / out_stall carry year, month, day_of_month, hour,
// minute and second, held in an output register until taken.
// Configuration: cfg_valid / cfg_ready write zone_offset_seconds (signed seconds
// added before the split); cfg_ready is always high. Write only while idle.
// Sequencing: one shared subtract-and-compare unit does all the work: 16 steps
// for days and seconds of day, one step per year walked from 1970 (up to 69),
// up to 12 for the months, 5 for the hour and 6 for the minute. The year walk
// is the part whose length varies from request to request.
// Throughput: one request at a time; a new request is taken once the previous
// result has reached the output register.
// Reset: clears the sequencer and the output valid and loads the offset with
// +8 hours. No clearing pass is needed.
// Stall: a held result keeps the output register; the finished sequencer waits
// in its last state and holds in_stall until the register frees up.
`include "epoch_seconds_to_calendar_assert.svh"

module epoch_seconds_to_calendar import esc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [30:0]        epoch_seconds,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [10:0]        year,
	output logic [3:0]         month,
	output logic [4:0]         day_of_month,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic signed [16:0] cfg_data
);

	logic signed [16:0] offset_q;
	logic               out_valid_q;
	esc_result_t        out_q;

	logic        start;
	logic        busy;
	logic        done;
	logic        load_ok;
	esc_result_t result;

	// Offset register: always ready, writes are registered
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= $signed(OFFSET_RESET);
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	// Take a request only while the sequencer is idle
	assign in_stall = busy;
	assign start    = in_valid && !in_stall;

	// Output slot is free when empty or being drained this cycle
	assign load_ok = !out_valid_q || !out_stall;

	esc_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.epoch   (epoch_seconds),
		.offset  (offset_q),
		.load_ok (load_ok),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	// Output register: load on completion, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign year         = out_q.year;
	assign month        = out_q.month;
	assign day_of_month = out_q.day_of_month;
	assign hour         = out_q.hour;
	assign minute       = out_q.minute;
	assign second       = out_q.second;

	// A taken request must leave the input stalled while it is worked on
	`ESC_ASSERT_NEXT(a_busy_after_start, start, in_stall)
	// A presented result carries a real month, a real time of day and a year from 1970 on
	`ESC_ASSERT_IMPLY(a_month_range, out_valid_q, month >= 4'd1 && month <= 4'd12)
	`ESC_ASSERT_IMPLY(a_time_range, out_valid_q,
		hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 && year >= FIRST_YEAR)

endmodule

@@ sv/esc_sub_unit.sv @@
module esc_sub_unit import esc_pkg::*; (
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output logic [WORD_W-1:0] diff,
	output logic              ge
);

	logic [WORD_W:0] full;

	// borrow out clear means a >= b
	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[WORD_W-1:0];
	assign ge   = ~full[WORD_W];

endmodule

@@ sv/esc_seq.sv @@
module esc_seq import esc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [30:0]       epoch,
	input  logic signed [16:0] offset,
	input  logic              load_ok,
	output logic              busy,
	output logic              done,
	output esc_result_t       result
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DAYS  = 3'd1;
	localparam logic [2:0] ST_YEAR  = 3'd2;
	localparam logic [2:0] ST_MONTH = 3'd3;
	localparam logic [2:0] ST_HOUR  = 3'd4;
	localparam logic [2:0] ST_MIN   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]        state_q;
	logic [3:0]        step_q;
	logic [WORD_W-1:0] rem_q;
	logic [15:0]       quot_q;
	logic [16:0]       sod_q;
	logic [1:0]        y4_q;
	logic [6:0]        y100_q;
	logic [8:0]        y400_q;
	esc_result_t       res_q;

	logic [WORD_W-1:0] op_b;
	logic [WORD_W-1:0] diff;
	logic              ge;
	logic              leap;
	logic [15:0]       quot_next;
	logic [WORD_W-1:0] rem_next;
	logic signed [32:0] total;

	assign leap      = esc_is_leap(y4_q, y100_q, y400_q);
	assign quot_next = {quot_q[14:0], ge};
	assign rem_next  = ge ? diff : rem_q;
	assign total     = $signed({2'b00, epoch}) + 33'(offset);

	always_comb begin
		unique case (state_q)
			ST_DAYS:  op_b = WORD_W'(DAY_SECONDS) << step_q;
			ST_YEAR:  op_b = WORD_W'(esc_year_len(leap));
			ST_MONTH: op_b = WORD_W'(esc_month_len(res_q.month, leap));
			ST_HOUR:  op_b = WORD_W'(HOUR_SECONDS) << step_q;
			ST_MIN:   op_b = WORD_W'(MIN_SECONDS) << step_q;
			default:  op_b = '0;
		endcase
	end

	esc_sub_unit u_sub (
		.a    (rem_q),
		.b    (op_b),
		.diff (diff),
		.ge   (ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (start) state_q <= ST_DAYS;
				ST_DAYS:  if (step_q == 4'd0) state_q <= ST_YEAR;
				ST_YEAR:  if (!ge) state_q <= ST_MONTH;
				ST_MONTH: if (res_q.month == 4'd12 || !ge) state_q <= ST_HOUR;
				ST_HOUR:  if (step_q == 4'd0) state_q <= ST_MIN;
				ST_MIN:   if (step_q == 4'd0) state_q <= ST_DONE;
				ST_DONE:  if (load_ok) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rem_q  <= total[32] ? '0 : total[WORD_W-1:0];
				quot_q <= '0;
				step_q <= 4'd15;
			end
			ST_DAYS: begin
				quot_q <= quot_next;
				step_q <= step_q - 4'd1;
				if (step_q == 4'd0) begin
					rem_q     <= WORD_W'(quot_next);
					sod_q     <= rem_next[16:0];
					res_q.year <= FIRST_YEAR;
					y4_q      <= FIRST_Y4;
					y100_q    <= FIRST_Y100;
					y400_q    <= FIRST_Y400;
				end else begin
					rem_q <= rem_next;
				end
			end
			ST_YEAR: begin
				if (ge) begin
					rem_q      <= diff;
					res_q.year <= res_q.year + 11'd1;
					y4_q       <= y4_q + 2'd1;
					y100_q     <= (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
					y400_q     <= (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
				end else begin
					res_q.month <= 4'd1;
				end
			end
			ST_MONTH: begin
				if (res_q.month != 4'd12 && ge) begin
					rem_q       <= diff;
					res_q.month <= res_q.month + 4'd1;
				end else begin
					res_q.day_of_month <= rem_q[4:0] + 5'd1;
					rem_q  <= WORD_W'(sod_q);
					quot_q <= '0;
					step_q <= 4'd4;
				end
			end
			ST_HOUR: begin
				rem_q <= rem_next;
				if (step_q == 4'd0) begin
					res_q.hour <= quot_next[4:0];
					quot_q     <= '0;
					step_q     <= 4'd5;
				end else begin
					quot_q <= quot_next;
					step_q <= step_q - 4'd1;
				end
			end
			ST_MIN: begin
				rem_q  <= rem_next;
				quot_q <= quot_next;
				step_q <= step_q - 4'd1;
				if (step_q == 4'd0) begin
					res_q.minute <= quot_next[5:0];
					res_q.second <= rem_next[5:0];
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_DONE) && load_ok;
	assign result = res_q;

endmodule
